@@ rtl/sdmn_pkg.sv @@
`default_nettype none
package sdmn_pkg;

	localparam int unsigned DATA_W    = 64;
	localparam int unsigned SHIFT_W   = 6;
	localparam int unsigned CNT_W     = 7;
	localparam logic [CNT_W-1:0] STEP_MAX = CNT_W'(64);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);
	localparam logic [DATA_W-1:0] TOP     = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV2,
		ST_ANC,
		ST_DIV1,
		ST_STEP1,
		ST_STEP2,
		ST_DELTA,
		ST_TEST,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

@@ rtl/signed_div_magic_number_top.sv @@
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     divisor
// out      output     out_valid / out_ready   valid_res, magic, post_shift
//
// a divisor below two is rejected and gives a zero result with valid_res low
// otherwise 2^63 / d, then anc, then 2^63 / anc, then doubling steps through
// STEP1, STEP2, DELTA and TEST (at most 64 steps), all through one compare-subtract unit
// arst_n clears the sequencer and the output valid
// the result waits in the output register; a new divisor is taken meanwhile
`default_nettype none
module signed_div_magic_number_top
	import sdmn_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DATA_W-1:0] divisor,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          valid_res,
	output logic signed [DATA_W-1:0]      magic,
	output logic [SHIFT_W-1:0]            post_shift
);

	state_t state_q, state_d;

	logic [DATA_W-1:0] d_q, anc_q, q1_q, r1_q, q2_q, r2_q, delta_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ok_q;

	logic                 out_valid_q, valid_res_q;
	logic [DATA_W-1:0]    magic_q;
	logic [SHIFT_W-1:0]   post_shift_q;

	logic                 in_hs, slot_free, div_ok;
	logic                 use1, bit_in, cont;
	logic [DATA_W-1:0]    u_rem, u_quo, u_div, u_sh, u_rem_n, u_quo_n;
	logic [DATA_W:0]      u_diff;
	logic                 u_ge;

	assign in_hs     = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign div_ok    = !divisor[DATA_W-1] && (divisor > DATA_W'(1));

	// shared compare-subtract unit
	always_comb begin
		use1    = (state_q == ST_DIV1) || (state_q == ST_STEP1);
		bit_in  = (state_q == ST_DIV2 || state_q == ST_DIV1) && (cnt_q == '0);
		u_rem   = use1 ? r1_q : r2_q;
		u_quo   = use1 ? q1_q : q2_q;
		u_div   = use1 ? anc_q : d_q;
		u_sh    = {u_rem[DATA_W-2:0], bit_in};
		u_diff  = {1'b0, u_sh} - {1'b0, u_div};
		u_ge    = !u_diff[DATA_W];
		u_rem_n = u_ge ? u_diff[DATA_W-1:0] : u_sh;
		u_quo_n = {u_quo[DATA_W-2:0], u_ge};
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cont     = ((q1_q < delta_q) || ((q1_q == delta_q) && (r1_q == '0)))
			&& (cnt_q < STEP_MAX);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_hs) state_d = div_ok ? ST_DIV2 : ST_FIN;
			ST_DIV2:  if (cnt_q == DIV_LAST) state_d = ST_ANC;
			ST_ANC:   state_d = ST_DIV1;
			ST_DIV1:  if (cnt_q == DIV_LAST) state_d = ST_STEP1;
			ST_STEP1: state_d = ST_STEP2;
			ST_STEP2: state_d = ST_DELTA;
			ST_DELTA: state_d = ST_TEST;
			ST_TEST:  state_d = cont ? ST_STEP1 : ST_FIN;
			ST_FIN:   if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				d_q   <= divisor;
				ok_q  <= div_ok;
				q2_q  <= '0;
				r2_q  <= '0;
				cnt_q <= '0;
			end
			ST_DIV2: begin
				q2_q  <= u_quo_n;
				r2_q  <= u_rem_n;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_ANC: begin
				anc_q <= TOP - DATA_W'(1) - r2_q;
				q1_q  <= '0;
				r1_q  <= '0;
				cnt_q <= '0;
			end
			ST_DIV1: begin
				q1_q  <= u_quo_n;
				r1_q  <= u_rem_n;
				cnt_q <= (cnt_q == DIV_LAST) ? '0 : cnt_q + CNT_W'(1);
			end
			ST_STEP1: begin
				q1_q <= u_quo_n;
				r1_q <= u_rem_n;
			end
			ST_STEP2: begin
				q2_q  <= u_quo_n;
				r2_q  <= u_rem_n;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_DELTA: delta_q <= d_q - r2_q;
			ST_TEST, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			valid_res_q  <= ok_q;
			magic_q      <= ok_q ? q2_q + DATA_W'(1) : '0;
			post_shift_q <= ok_q ? SHIFT_W'(cnt_q - CNT_W'(1)) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign valid_res  = valid_res_q;
	assign magic      = magic_q;
	assign post_shift = post_shift_q;

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_hs |=> (state_q == ST_DIV2 || state_q == ST_FIN))
		else $error("bad state after accepted transaction");

	a_rem_below_d: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ANC) |-> (r2_q < d_q))
		else $error("remainder not below divisor");

	a_anc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1) |-> (anc_q != '0))
		else $error("anc is zero");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> (cnt_q != '0 && cnt_q <= STEP_MAX))
		else $error("step count out of range");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (magic == '0 && post_shift == '0))
		else $error("rejected divisor with nonzero result");

endmodule
`default_nettype wire
